>>> hw/rtl/slpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpe_pkg
// Shared types and constants for the status LED pixel encoder.
// ----------------------------------------------------------------------------
package slpe_pkg;

  // Blink periods in milliseconds (zero means always on)
  localparam int unsigned FAST_BLINK_MS        = 500;
  localparam int unsigned SLOW_BLINK_MS_PERIOD = 1000;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned TICK_W  = 4;

  localparam int unsigned NUM_SYMBOLS = 24;
  localparam int unsigned SYM_CNT_W   = $clog2(NUM_SYMBOLS);

  localparam logic [TICK_W-1:0] TICKS_LONG  = 4'd8;
  localparam logic [TICK_W-1:0] TICKS_SHORT = 4'd4;

  // Reciprocal constants: floor(t / D) == (t * M) >> S for all 32-bit t,
  // with S = 32 + clog2(D) and M = ceil(2^S / D). M fits in 33 bits.
  localparam int unsigned MAGIC_W = TIME_W + 1;
  localparam int unsigned PROD_W  = TIME_W + MAGIC_W;

  localparam bit          FAST_ALWAYS_ON = (FAST_BLINK_MS == 0);
  localparam int unsigned FAST_DIV   = FAST_ALWAYS_ON ? 1 : FAST_BLINK_MS;
  localparam int unsigned FAST_SHIFT = TIME_W + $clog2(FAST_DIV);
  localparam logic [MAGIC_W-1:0] FAST_MAGIC =
    MAGIC_W'(((64'd1 << FAST_SHIFT) + 64'(FAST_DIV) - 64'd1) / 64'(FAST_DIV));

  localparam bit          SLOW_ALWAYS_ON = (SLOW_BLINK_MS_PERIOD == 0);
  localparam int unsigned SLOW_DIV   = SLOW_ALWAYS_ON ? 1 : SLOW_BLINK_MS_PERIOD;
  localparam int unsigned SLOW_SHIFT = TIME_W + $clog2(SLOW_DIV);
  localparam logic [MAGIC_W-1:0] SLOW_MAGIC =
    MAGIC_W'(((64'd1 << SLOW_SHIFT) + 64'(SLOW_DIV) - 64'd1) / 64'(SLOW_DIV));

  // Register reset values
  localparam logic [COLOR_W-1:0] RST_COLOR_DISCONNECTED  = 24'hFF7800;
  localparam logic [COLOR_W-1:0] RST_COLOR_CONNECTED     = 24'h00B4FF;
  localparam logic [COLOR_W-1:0] RST_COLOR_DEV_READY     = 24'h00FF00;
  localparam logic [COLOR_W-1:0] RST_COLOR_PRINTING      = 24'h0050FF;
  localparam logic [COLOR_W-1:0] RST_COLOR_ERROR         = 24'hFF0000;
  localparam logic               RST_LED_ENABLE          = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_DISCONNECTED  = 3'd0,
    REG_COLOR_CONNECTED     = 3'd1,
    REG_COLOR_DEV_READY     = 3'd2,
    REG_COLOR_PRINTING      = 3'd3,
    REG_COLOR_ERROR         = 3'd4,
    REG_LED_ENABLE          = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SCEN_NONE     = 3'd0,
    SCEN_LINK     = 3'd1,
    SCEN_READY    = 3'd2,
    SCEN_PRINTING = 3'd3,
    SCEN_ERROR    = 3'd4
  } scen_t;

  // One pixel request: color already in wire order (green, red, blue)
  typedef struct packed {
    logic [COLOR_W-1:0] grb;
    scen_t              scen;
  } pixel_t;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Queue status seen by the producer and the consumer
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> hw/rtl/slpe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpe_front
// Holds the config registers, picks the scenario, resolves the blink phase
// and queues one GRB pixel request per accepted tick while the LED is enabled.
// ----------------------------------------------------------------------------
module slpe_front import slpe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_usb_error,
  input  logic                 in_jobs_active,
  input  logic                 in_dev_ready,
  input  logic                 in_link_connected,
  input  logic [TIME_W-1:0]    in_time_ms,
  output logic                 push,
  output pixel_t               push_data,
  input  queue_status_t        q_status
);

  logic [COLOR_W-1:0] color_disc_r, color_conn_r, color_ready_r;
  logic [COLOR_W-1:0] color_print_r, color_err_r;
  logic               led_enable_r;

  logic   vld_r, vld_nxt;
  pixel_t pix_r;

  logic               accept;
  scen_t              scen;
  logic               use_slow;
  logic               blinks;
  logic [MAGIC_W-1:0] magic;
  logic [PROD_W-1:0]  prod;
  logic               odd_period;
  logic               led_on;
  logic [COLOR_W-1:0] rgb;
  pixel_t             pix_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_disc_r  <= RST_COLOR_DISCONNECTED;
      color_conn_r  <= RST_COLOR_CONNECTED;
      color_ready_r <= RST_COLOR_DEV_READY;
      color_print_r <= RST_COLOR_PRINTING;
      color_err_r   <= RST_COLOR_ERROR;
      led_enable_r  <= RST_LED_ENABLE;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COLOR_DISCONNECTED:  color_disc_r  <= cfg_wdata;
        REG_COLOR_CONNECTED:     color_conn_r  <= cfg_wdata;
        REG_COLOR_DEV_READY:     color_ready_r <= cfg_wdata;
        REG_COLOR_PRINTING:      color_print_r <= cfg_wdata;
        REG_COLOR_ERROR:         color_err_r   <= cfg_wdata;
        REG_LED_ENABLE:          led_enable_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (in_usb_error)      scen = SCEN_ERROR;
    else if (in_jobs_active)        scen = SCEN_PRINTING;
    else if (in_dev_ready)          scen = SCEN_READY;
    else if (in_link_connected)     scen = SCEN_LINK;
    else                            scen = SCEN_NONE;
  end

  // Blink phase: parity of time / period via reciprocal multiply
  always_comb begin
    use_slow   = (scen == SCEN_NONE);
    blinks     = (scen == SCEN_NONE) || (scen == SCEN_PRINTING) || (scen == SCEN_ERROR);
    magic      = use_slow ? SLOW_MAGIC : FAST_MAGIC;
    prod       = PROD_W'(in_time_ms) * PROD_W'(magic);
    odd_period = use_slow ? prod[SLOW_SHIFT] : prod[FAST_SHIFT];
    led_on     = !blinks || (use_slow ? SLOW_ALWAYS_ON : FAST_ALWAYS_ON) || !odd_period;
  end

  always_comb begin
    unique case (scen)
      SCEN_NONE:     rgb = color_disc_r;
      SCEN_LINK:     rgb = color_conn_r;
      SCEN_READY:    rgb = color_ready_r;
      SCEN_PRINTING: rgb = color_print_r;
      SCEN_ERROR:    rgb = color_err_r;
      default:       rgb = '0;
    endcase
    pix_nxt.scen = scen;
    pix_nxt.grb  = led_on ? {rgb[15:8], rgb[23:16], rgb[7:0]} : '0;
  end

  assign in_stall  = vld_r && q_status.full;
  assign accept    = in_valid && !in_stall;
  assign push      = vld_r && !q_status.full;
  assign push_data = pix_r;

  // A disabled LED still takes the tick but queues nothing
  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = led_enable_r;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r <= pix_nxt;
    end
  end

endmodule

>>> hw/rtl/slpe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpe_queue
// Short request queue between the front end and the symbol serializer.
// ----------------------------------------------------------------------------
module slpe_queue import slpe_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pixel_t        push_data,
  input  logic          pop,
  output pixel_t        pop_data,
  output queue_status_t status
);

  pixel_t                 mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hw/rtl/slpe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpe_back
// Symbol serializer: shifts one queued pixel out MSB first, one one-wire
// symbol per cycle while out_stall is low, from a registered output stage.
// ----------------------------------------------------------------------------
module slpe_back import slpe_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  output logic                pop,
  input  pixel_t              pop_data,
  input  queue_status_t       q_status,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [TICK_W-1:0]   out_high_ticks,
  output logic [TICK_W-1:0]   out_low_ticks,
  output logic                out_bit_value,
  output logic [2:0]          out_scenario_code,
  output logic                out_last_symbol
);

  logic                 valid_r, valid_nxt;
  logic [COLOR_W-1:0]   shift_r, shift_nxt;
  scen_t                scen_r, scen_nxt;
  logic [SYM_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 last;
  logic                 take;

  assign last = (cnt_r == SYM_CNT_W'(NUM_SYMBOLS - 1));
  assign take = valid_r && !out_stall;
  // Next pixel loads as the last symbol of the current one is taken
  assign pop  = !q_status.empty && (!valid_r || (take && last));

  always_comb begin
    valid_nxt = valid_r;
    shift_nxt = shift_r;
    scen_nxt  = scen_r;
    cnt_nxt   = cnt_r;
    if (pop) begin
      valid_nxt = 1'b1;
      shift_nxt = pop_data.grb;
      scen_nxt  = pop_data.scen;
      cnt_nxt   = '0;
    end else if (take) begin
      if (last) begin
        valid_nxt = 1'b0;
      end else begin
        shift_nxt = {shift_r[COLOR_W-2:0], 1'b0};
        cnt_nxt   = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    scen_r  <= scen_nxt;
  end

  assign out_valid         = valid_r;
  assign out_bit_value     = shift_r[COLOR_W-1];
  assign out_high_ticks    = shift_r[COLOR_W-1] ? TICKS_LONG : TICKS_SHORT;
  assign out_low_ticks     = shift_r[COLOR_W-1] ? TICKS_SHORT : TICKS_LONG;
  assign out_scenario_code = scen_r;
  assign out_last_symbol   = last;

endmodule

>>> hw/rtl/status_led_pixel_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_led_pixel_encoder
// Status tick to one-wire LED symbol encoder: front end, request queue and
// symbol serializer.
// ----------------------------------------------------------------------------
// Path: an accepted tick passes the front-end pixel register, the request
//   queue and the serializer output register before its first symbol shows.
// Throughput: one symbol per cycle while not stalled, set by the serializer;
//   with the LED disabled a tick is taken every cycle and produces nothing.
// Reset: synchronous, active low; clears the queue and serializer and restores
//   the default colors with the LED enabled.
// ----------------------------------------------------------------------------
module status_led_pixel_encoder import slpe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_usb_error,
  input  logic                 in_jobs_active,
  input  logic                 in_dev_ready,
  input  logic                 in_link_connected,
  input  logic [TIME_W-1:0]    in_time_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [TICK_W-1:0]    out_high_ticks,
  output logic [TICK_W-1:0]    out_low_ticks,
  output logic                 out_bit_value,
  output logic [2:0]           out_scenario_code,
  output logic                 out_last_symbol
);

  logic          push;
  logic          pop;
  pixel_t        push_data;
  pixel_t        pop_data;
  queue_status_t q_status;

  slpe_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_usb_error      (in_usb_error),
    .in_jobs_active    (in_jobs_active),
    .in_dev_ready      (in_dev_ready),
    .in_link_connected (in_link_connected),
    .in_time_ms        (in_time_ms),
    .push              (push),
    .push_data         (push_data),
    .q_status          (q_status)
  );

  slpe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  slpe_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pop               (pop),
    .pop_data          (pop_data),
    .q_status          (q_status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_high_ticks    (out_high_ticks),
    .out_low_ticks     (out_low_ticks),
    .out_bit_value     (out_bit_value),
    .out_scenario_code (out_scenario_code),
    .out_last_symbol   (out_last_symbol)
  );

endmodule
